FILE: sv/rpn_stack_evaluator_macros.svh
// assertion macros for the reverse polish stack evaluator
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// property checked on every clock edge outside reset
`define RPNSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RPNSE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/rpnse_pkg.sv
// shared constants, types and helpers of the rpn stack evaluator
package rpnse_pkg;

  localparam int StackDepth = 16;
  localparam int FracBits   = 16;

  localparam int DataW     = 32;
  localparam int OpW       = 3;
  localparam int StatusW   = 3;
  localparam int DepthOutW = 5;
  localparam int SpW       = $clog2(StackDepth + 1);
  localparam int AddrW     = $clog2(StackDepth);
  localparam int DivW      = DataW + FracBits;
  localparam int ProdW     = 2 * DataW;

  localparam logic [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_SAT   = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic tok_load;
    logic dec;
    logic a_load;
    logic exe;
    logic fin;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_a;
    logic go_mul;
    logic go_div;
    logic div_last;
  } sts_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             sat;
  } sat_t;

  // clamp a 33-bit two's complement sum to 32 bits
  function automatic sat_t clamp_sum(input logic [DataW:0] s);
    sat_t r;
    r.sat   = s[DataW] ^ s[DataW-1];
    r.value = r.sat ? (s[DataW] ? MinVal : MaxVal) : s[DataW-1:0];
    return r;
  endfunction

  // clamp a sign and magnitude pair to the signed 32-bit range
  function automatic sat_t clamp_mag(input logic neg, input logic [ProdW-1:0] mag);
    sat_t r;
    if (!neg) begin
      r.sat   = mag > ProdW'(MaxVal);
      r.value = r.sat ? MaxVal : mag[DataW-1:0];
    end else begin
      r.sat   = mag > ProdW'(MinVal);
      r.value = r.sat ? MinVal : (DataW'(0) - mag[DataW-1:0]);
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] mag_of(input logic [DataW-1:0] v);
    return v[DataW-1] ? (DataW'(0) - v) : v;
  endfunction

endpackage

FILE: sv/rpnse_ram.sv
// generic single write port ram with registered read
module rpnse_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rpnse_div.sv
// restoring divider, one quotient bit per cycle
module rpnse_div import rpnse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic [DivW-1:0]  quotient_o,
  output logic             last_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] dsr_q;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DivW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
    quo_d   = {quo_q[DivW-2:0], ge};
    cnt_d   = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DivW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = cnt_q == CntW'(1);

endmodule

FILE: sv/rpnse_dp.sv
// datapath: token register, stack ram with top register, alu and output register
module rpnse_dp import rpnse_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [DataW-1:0] token_value_i,
  input  logic                    starts_expression_i,
  output logic signed [DataW-1:0] top_value_o,
  output logic [DepthOutW-1:0]    stack_depth_o,
  output logic [StatusW-1:0]      status_o
);

  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] val_q;
  logic             clr_q;
  logic [SpW-1:0]   sp_q, sp_d, sp_eff;
  logic [DataW-1:0] top_q, top_d;
  logic [DataW-1:0] a_q;
  logic             neg_q;
  logic [ProdW-1:0] prod_q, prod_d;
  status_e          status_q, status_d;

  logic [DataW-1:0]     out_top_q;
  logic [DepthOutW-1:0] out_depth_q;
  status_e              out_status_q;

  logic             ram_we, ram_re;
  logic [SpW-1:0]   waddr_full, raddr_full;
  logic [DataW-1:0] ram_rdata;

  logic [DataW-1:0] mag_a, mag_b;
  logic             res_neg, b_zero;
  sat_t             add_res, sub_res, fin_res;
  logic [ProdW-1:0] fin_mag;
  logic [DivW-1:0]  dividend, quotient;
  logic             div_start, div_last;
  logic [SpW+DepthOutW-1:0] depth_wide;

  assign sp_eff     = clr_q ? '0 : sp_q;
  assign waddr_full = sp_eff - 1'b1;
  assign raddr_full = sp_eff - SpW'(2);

  rpnse_ram #(
    .Width (DataW),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_full[AddrW-1:0]),
    .wdata_i (top_q),
    .re_i    (ram_re),
    .raddr_i (raddr_full[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // a is the entry below the top, b the top itself
  assign mag_a    = mag_of(a_q);
  assign mag_b    = mag_of(top_q);
  assign res_neg  = a_q[DataW-1] ^ top_q[DataW-1];
  assign b_zero   = top_q == '0;
  assign add_res  = clamp_sum({a_q[DataW-1], a_q} + {top_q[DataW-1], top_q});
  assign sub_res  = clamp_sum({a_q[DataW-1], a_q} - {top_q[DataW-1], top_q});
  assign prod_d   = mag_a * mag_b;
  assign dividend = {mag_a, {FracBits{1'b0}}};
  assign div_start = cmd_i.exe && (op_q == OP_DIV) && !b_zero;

  rpnse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (mag_b),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  assign fin_mag = (op_q == OP_MUL) ? (prod_q >> FracBits) : ProdW'(quotient);
  assign fin_res = clamp_mag(neg_q, fin_mag);

  always_comb begin
    sp_d     = sp_q;
    top_d    = top_q;
    status_d = status_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    if (cmd_i.dec) begin
      sp_d     = sp_eff;
      status_d = ST_OK;
      case (op_q)
        OP_PUSH: begin
          if (sp_eff >= SpW'(StackDepth)) begin
            status_d = ST_FULL;
          end else begin
            // old top spills into the ram
            ram_we = sp_eff != '0;
            top_d  = val_q;
            sp_d   = sp_eff + 1'b1;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (sts_o.need_a) begin
            ram_re = 1'b1;
          end else begin
            status_d = ST_UNDER;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.exe) begin
      case (op_q)
        OP_ADD: begin
          top_d    = add_res.value;
          status_d = add_res.sat ? ST_SAT : ST_OK;
          sp_d     = sp_q - 1'b1;
        end
        OP_SUB: begin
          top_d    = sub_res.value;
          status_d = sub_res.sat ? ST_SAT : ST_OK;
          sp_d     = sp_q - 1'b1;
        end
        OP_DIV: begin
          if (b_zero) begin
            top_d    = a_q[DataW-1] ? MinVal : MaxVal;
            status_d = ST_DIV0;
            sp_d     = sp_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.fin) begin
      top_d    = fin_res.value;
      status_d = fin_res.sat ? ST_SAT : ST_OK;
      sp_d     = sp_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    status_q <= status_d;
    if (cmd_i.tok_load) begin
      op_q  <= opcode_i;
      val_q <= token_value_i;
      clr_q <= starts_expression_i;
    end
    if (cmd_i.a_load) begin
      a_q <= ram_rdata;
    end
    if (cmd_i.exe) begin
      prod_q <= prod_d;
      neg_q  <= res_neg;
    end
    if (cmd_i.out_load) begin
      out_top_q    <= (sp_q != '0) ? top_q : '0;
      out_depth_q  <= depth_wide[DepthOutW-1:0];
      out_status_q <= status_q;
    end
  end

  assign depth_wide = (SpW + DepthOutW)'(sp_q);

  assign sts_o.need_a   = (op_q inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) &&
                          (sp_eff >= SpW'(2));
  assign sts_o.go_mul   = op_q == OP_MUL;
  assign sts_o.go_div   = (op_q == OP_DIV) && !b_zero;
  assign sts_o.div_last = div_last;

  assign top_value_o   = out_top_q;
  assign stack_depth_o = out_depth_q;
  assign status_o      = out_status_q;

endmodule

FILE: sv/rpnse_ctrl.sv
// controller: token sequencing and output handshake
module rpnse_ctrl import rpnse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RDA  = 7'b0000100,
    S_EXE  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_WB   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.tok_load = 1'b1;
          state_d        = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = sts_i.need_a ? S_RDA : S_WB;
      end
      S_RDA: begin
        cmd_o.a_load = 1'b1;
        state_d      = S_EXE;
      end
      S_EXE: begin
        cmd_o.exe = 1'b1;
        if (sts_i.go_mul) begin
          state_d = S_FIN;
        end else if (sts_i.go_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/rpn_stack_evaluator.sv
// top level of the reverse polish stack evaluator
//
//   channel | direction | beat contents
//   --------+-----------+--------------------------------------------------
//   in      | sink      | opcode_i, token_value_i, starts_expression_i
//   out     | source    | top_value_o, stack_depth_o, status_o
//
// states per token: idle, decode and write-back for push, unused opcode or rejected
// token; add, subtract or divide by zero add operand read and execute; multiply adds
// finish; divide adds the restoring divider, one quotient bit per cycle, then finish
// reset empties the stack; stack ram contents stay undefined until pushed
// a result waiting in the output register does not hold off the next token,
// only the write-back of the following result waits for it to drain
module rpn_stack_evaluator import rpnse_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // token beats
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [DataW-1:0] token_value_i,
  input  logic                    starts_expression_i,
  // result beats
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] top_value_o,
  output logic [DepthOutW-1:0]    stack_depth_o,
  output logic [StatusW-1:0]      status_o
);

`include "rpn_stack_evaluator_macros.svh"

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one token in flight, output register handshake
  rpnse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: top of stack kept in a register, lower entries in ram,
  // adder, 32x32 multiplier and bit-serial divider
  rpnse_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .opcode_i            (opcode_i),
    .token_value_i       (token_value_i),
    .starts_expression_i (starts_expression_i),
    .top_value_o         (top_value_o),
    .stack_depth_o       (stack_depth_o),
    .status_o            (status_o)
  );

  // one token at a time: no beat is taken right after an accepted one
  `RPNSE_ASSERT(a_one_token, (in_valid_i && in_ready_o) |=> !in_ready_o, "token overlap")
  // an empty stack always reports a zero top
  `RPNSE_ASSERT(a_empty_top, (out_valid_o && stack_depth_o == '0) |-> (top_value_o == '0), "empty stack top not zero")
  // a dropped push only happens on a full stack
  `RPNSE_ASSERT(a_full_depth, (out_valid_o && status_o == ST_FULL) |-> (stack_depth_o == DepthOutW'(StackDepth)), "full status with room left")
  // underflow only with fewer than two entries
  `RPNSE_NEVER(a_under_depth, out_valid_o && status_o == ST_UNDER && stack_depth_o >= DepthOutW'(2), "underflow with operands present")

endmodule
